/* rtl/particle_verlet_kick_drift_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the particle kick/drift integrator
// Clock clk and active-low reset rst_n are taken from the using scope.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_VERLET_KICK_DRIFT_DEFINES_SVH
`define PARTICLE_VERLET_KICK_DRIFT_DEFINES_SVH

`ifndef SYNTHESIS
// Implication checked at every edge out of reset
`define PVKD_AST_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pvkd implication violated");
// Condition that must never hold
`define PVKD_AST_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pvkd forbidden condition seen");
`else
`define PVKD_AST_IMPL(name, ante, cons)
`define PVKD_AST_NEVER(name, cond)
`endif

`endif

/* rtl/pvkd_pkg.sv */
// ----------------------------------------------------------------------------
// pvkd_pkg
// Shared constants and codes for the particle kick/drift integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package pvkd_pkg;

  localparam int DW            = 32;  // data word
  localparam int FRAC_BITS_DEF = 16;
  localparam int PROD_W        = 62;  // half step * |force| < 2^62
  localparam int MD_W          = 64;  // mass * weight
  localparam int QB            = 34;  // quotient bits, cap is 2^33
  localparam int DIV_LAT       = QB + 1;
  localparam int CFG_IDX_W     = 1;

  localparam logic [QB-1:0] QCAP = {1'b1, {(QB-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_KICK       = 2'd0,
    CMD_DRIFT      = 2'd1,
    CMD_KICK_DRIFT = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP = 1'b0,
    CFG_WEIGHTING = 1'b1
  } cfg_idx_e;

endpackage

`default_nettype wire

/* rtl/particle_verlet_kick_drift.sv */
// ----------------------------------------------------------------------------
// particle_verlet_kick_drift
// Velocity Verlet kick/drift step for one particle per item, fully pipelined.
// ----------------------------------------------------------------------------
// One item may be started in every clock cycle; busy is high only while reset
// is held. Each item's result appears on the out_ ports for a single cycle
// with out_valid high, in start order. The receiver cannot stall the block,
// so results must be captured when out_valid is seen. The latency is set by
// the kick divider: one quotient bit a stage over 34 stages plus a range
// check, with input, multiply, kick, drift multiply and drift add stages
// around it. Configuration may be written only while no items are in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "particle_verlet_kick_drift_defines.svh"

module particle_verlet_kick_drift
  import pvkd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // command channel
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_command,
  input  wire logic [DW-1:0]        in_position_x,
  input  wire logic [DW-1:0]        in_position_y,
  input  wire logic [DW-1:0]        in_position_z,
  input  wire logic [DW-1:0]        in_velocity_x,
  input  wire logic [DW-1:0]        in_velocity_y,
  input  wire logic [DW-1:0]        in_velocity_z,
  input  wire logic [DW-1:0]        in_force_x,
  input  wire logic [DW-1:0]        in_force_y,
  input  wire logic [DW-1:0]        in_force_z,
  input  wire logic [DW-1:0]        in_particle_mass,
  input  wire logic [DW-1:0]        in_particle_weight,
  // result channel
  output logic                      out_valid,
  output logic [DW-1:0]             out_new_position_x,
  output logic [DW-1:0]             out_new_position_y,
  output logic [DW-1:0]             out_new_position_z,
  output logic [DW-1:0]             out_new_velocity_x,
  output logic [DW-1:0]             out_new_velocity_y,
  output logic [DW-1:0]             out_new_velocity_z,
  output logic                      out_saturated,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DW-1:0]        cfg_wdata
);

  localparam int NW  = PROD_W + FRAC_BITS;
  localparam int KW  = QB + 2;            // kick sum width
  localparam int LAT = DIV_LAT + 5;       // accept edge to result edge

  // items travel alongside the divider with this sideband
  typedef struct packed {
    cmd_e                 cmd;
    logic [2:0][DW-1:0]   pos;
    logic [2:0][DW-1:0]   vel;
    logic [2:0]           fneg;
  } sb_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [DW-1:0] ts_r;
  logic          wen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r  <= DW'(64'd1 << FRAC_BITS);
      wen_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_TIME_STEP: ts_r  <= cfg_wdata;
        CFG_WEIGHTING: wen_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: capture item, force magnitudes, clamp zero mass/weight to 1 LSB
  // --------------------------------------------------------------------------
  logic              in_acc;
  logic [2:0][DW-1:0] in_f;
  logic              s0_vld_r;
  sb_t               s0_sb_r;
  logic [2:0][DW-1:0] s0_fmag_r;
  logic [DW-1:0]     s0_m_r;
  logic [DW-1:0]     s0_w_r;

  assign busy   = ~rst_n;
  assign in_acc = start & ~busy;
  assign in_f   = {in_force_z, in_force_y, in_force_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    s0_sb_r.cmd <= cmd_e'(in_command);
    s0_sb_r.pos <= {in_position_z, in_position_y, in_position_x};
    s0_sb_r.vel <= {in_velocity_z, in_velocity_y, in_velocity_x};
    for (int i = 0; i < 3; i++) begin
      s0_sb_r.fneg[i] <= in_f[i][DW-1];
      s0_fmag_r[i]    <= in_f[i][DW-1] ? (~in_f[i] + 1'b1) : in_f[i];
    end
    s0_m_r <= (in_particle_mass == '0)   ? DW'(1) : in_particle_mass;
    s0_w_r <= (in_particle_weight == '0) ? DW'(1) : in_particle_weight;
  end

  // --------------------------------------------------------------------------
  // stage 1: half step * |force| per lane, mass * weight
  // --------------------------------------------------------------------------
  logic [DW-2:0]        half;
  logic                 s1_vld_r;
  sb_t                  s1_sb_r;
  logic [2:0][PROD_W-1:0] s1_hf_r;
  logic [MD_W-1:0]      s1_md_r;
  logic [DW-1:0]        s1_m_r;
  logic [2*DW-2:0]      hf_full [0:2];

  assign half = ts_r[DW-1:1];

  for (genvar i = 0; i < 3; i++) begin : g_hf
    assign hf_full[i] = half * s0_fmag_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_sb_r <= s0_sb_r;
    for (int i = 0; i < 3; i++) begin
      s1_hf_r[i] <= hf_full[i][PROD_W-1:0];
    end
    s1_md_r <= s0_m_r * s0_w_r;
    s1_m_r  <= s0_m_r;
  end

  // --------------------------------------------------------------------------
  // divider lanes: quotient of the kick, capped at 2^33
  // --------------------------------------------------------------------------
  logic [MD_W-1:0] div_d;
  logic [QB-1:0]   div_q [0:2];

  assign div_d = wen_r ? s1_md_r : {{(MD_W-DW){1'b0}}, s1_m_r};

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [NW-1:0] div_n;

    assign div_n = wen_r ? {s1_hf_r[i], {FRAC_BITS{1'b0}}}
                         : {{FRAC_BITS{1'b0}}, s1_hf_r[i]};

    pvkd_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk (clk),
      .n   (div_n),
      .d   (div_d),
      .q   (div_q[i])
    );
  end

  // sideband and valid line matching the divider depth
  sb_t                dly_r [0:DIV_LAT-1];
  logic [DIV_LAT-1:0] dly_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_vld_r <= '0;
    end else begin
      dly_vld_r <= {dly_vld_r[DIV_LAT-2:0], s1_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    dly_r[0] <= s1_sb_r;
    for (int k = 1; k < DIV_LAT; k++) begin
      dly_r[k] <= dly_r[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // kick stage: v +/- q, saturated
  // --------------------------------------------------------------------------
  sb_t              kin;
  logic             do_kick;
  logic [2:0][DW-1:0] kv_nxt;
  logic [2:0]       ksat;
  logic             sk_vld_r;
  cmd_e             sk_cmd_r;
  logic [2:0][DW-1:0] sk_pos_r;
  logic [2:0][DW-1:0] sk_vel_r;
  logic             sk_flag_r;

  assign kin     = dly_r[DIV_LAT-1];
  assign do_kick = (kin.cmd == CMD_KICK) || (kin.cmd == CMD_KICK_DRIFT);

  for (genvar i = 0; i < 3; i++) begin : g_kick
    logic [KW-1:0] vs;
    logic [KW-1:0] qs;
    logic [KW-1:0] ks;
    logic          fits;

    assign vs   = {{(KW-DW){kin.vel[i][DW-1]}}, kin.vel[i]};
    assign qs   = {{(KW-QB){1'b0}}, div_q[i]};
    assign ks   = kin.fneg[i] ? (vs - qs) : (vs + qs);
    assign fits = (&ks[KW-1:DW-1]) | ~(|ks[KW-1:DW-1]);

    always_comb begin
      kv_nxt[i] = kin.vel[i];
      ksat[i]   = 1'b0;
      if (do_kick) begin
        if (fits) begin
          kv_nxt[i] = ks[DW-1:0];
        end else begin
          kv_nxt[i] = ks[KW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
          ksat[i]   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_vld_r <= 1'b0;
    end else begin
      sk_vld_r <= dly_vld_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    sk_cmd_r  <= kin.cmd;
    sk_pos_r  <= kin.pos;
    sk_vel_r  <= kv_nxt;
    sk_flag_r <= |ksat;
  end

  // --------------------------------------------------------------------------
  // drift lanes (two stages) using the kicked velocity
  // --------------------------------------------------------------------------
  logic          do_drift;
  logic [DW-1:0] dpos [0:2];
  logic [2:0]    dsat;

  assign do_drift = (sk_cmd_r == CMD_DRIFT) || (sk_cmd_r == CMD_KICK_DRIFT);

  for (genvar i = 0; i < 3; i++) begin : g_drift
    pvkd_drift #(
      .FRAC_BITS (FRAC_BITS)
    ) u_drift (
      .clk   (clk),
      .x     (sk_pos_r[i]),
      .v     (sk_vel_r[i]),
      .t     (ts_r),
      .en    (do_drift),
      .x_new (dpos[i]),
      .sat   (dsat[i])
    );
  end

  // velocity, command and kick flag ride along the drift stages
  logic               d1_vld_r;
  cmd_e               d1_cmd_r;
  logic [2:0][DW-1:0] d1_vel_r;
  logic               d1_flag_r;
  logic               out_vld_r;
  cmd_e               out_cmd_r;
  logic [2:0][DW-1:0] out_vel_r;
  logic               out_flag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      d1_vld_r  <= sk_vld_r;
      out_vld_r <= d1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_cmd_r   <= sk_cmd_r;
    d1_vel_r   <= sk_vel_r;
    d1_flag_r  <= sk_flag_r;
    out_cmd_r  <= d1_cmd_r;
    out_vel_r  <= d1_vel_r;
    out_flag_r <= d1_flag_r;
  end

  // --------------------------------------------------------------------------
  // result ports
  // --------------------------------------------------------------------------
  assign out_valid          = out_vld_r;
  assign out_new_position_x = dpos[0];
  assign out_new_position_y = dpos[1];
  assign out_new_position_z = dpos[2];
  assign out_new_velocity_x = out_vel_r[0];
  assign out_new_velocity_y = out_vel_r[1];
  assign out_new_velocity_z = out_vel_r[2];
  assign out_saturated      = out_flag_r | (|dsat);

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `PVKD_AST_IMPL(a_item_emerges, $past(in_acc, LAT), out_valid)
  `PVKD_AST_IMPL(a_result_has_item, out_valid, $past(in_acc, LAT))
  `PVKD_AST_NEVER(a_nop_never_clips, out_valid && (out_cmd_r == CMD_NONE) && out_saturated)

endmodule

`default_nettype wire

/* rtl/pvkd_div.sv */
// ----------------------------------------------------------------------------
// pvkd_div
// Pipelined restoring divider, one quotient bit per stage, capped quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module pvkd_div
  import pvkd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic [PROD_W+FRAC_BITS-1:0] n,
  input  wire logic [MD_W-1:0]             d,
  output logic      [QB-1:0]               q
);

  localparam int NW = PROD_W + FRAC_BITS;
  localparam int HW = NW - QB;

  logic [MD_W-1:0] r_r    [0:QB-1];
  logic [MD_W-1:0] d_r    [0:QB-1];
  logic [QB-1:0]   nlo_r  [0:QB-1];
  logic            over_r [0:QB];
  logic [QB-1:0]   q_r    [1:QB];

  logic [MD_W-1:0] hi_ext;

  // quotient would reach 2^34 or more: capped anyway
  assign hi_ext = {{(MD_W-HW){1'b0}}, n[NW-1:QB]};

  always_ff @(posedge clk) begin
    r_r[0]    <= hi_ext;
    d_r[0]    <= d;
    nlo_r[0]  <= n[QB-1:0];
    over_r[0] <= (hi_ext >= d);
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [MD_W:0] rs;
    logic [MD_W:0] df;
    logic          ge;

    assign rs = {r_r[k-1], nlo_r[k-1][QB-1]};
    assign df = rs - {1'b0, d_r[k-1]};
    assign ge = ~df[MD_W];

    always_ff @(posedge clk) begin
      over_r[k] <= over_r[k-1];
    end

    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        q_r[k] <= {{(QB-1){1'b0}}, ge};
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        q_r[k] <= {q_r[k-1][QB-2:0], ge};
      end
    end

    if (k < QB) begin : g_carry
      always_ff @(posedge clk) begin
        r_r[k]   <= ge ? df[MD_W-1:0] : rs[MD_W-1:0];
        d_r[k]   <= d_r[k-1];
        nlo_r[k] <= {nlo_r[k-1][QB-2:0], 1'b0};
      end
    end
  end

  assign q = (over_r[QB] || (q_r[QB][QB-1] && (|q_r[QB][QB-2:0]))) ? QCAP : q_r[QB];

endmodule

`default_nettype wire

/* rtl/pvkd_drift.sv */
// ----------------------------------------------------------------------------
// pvkd_drift
// One position lane: x + (t * v) >> F when en is set, else x, saturated, two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pvkd_drift
  import pvkd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic [DW-1:0] x,
  input  wire logic [DW-1:0] v,
  input  wire logic [DW-1:0] t,
  input  wire logic          en,
  output logic      [DW-1:0] x_new,
  output logic               sat
);

  localparam int PW = 2 * DW;
  localparam int SW = PW + 1 - FRAC_BITS;

  logic [DW-1:0] vmag;
  logic [PW-1:0] prod_r;
  logic          vneg_r;
  logic [DW-1:0] x_r;
  logic          en_r;

  logic [SW-1:0] dx;
  logic [SW-1:0] xs;
  logic [SW-1:0] sum;
  logic          fits;
  logic [DW-1:0] x_nxt;
  logic          sat_nxt;
  logic [DW-1:0] x_new_r;
  logic          sat_r;

  assign vmag = v[DW-1] ? (~v + 1'b1) : v;

  always_ff @(posedge clk) begin
    prod_r <= t * vmag;
    vneg_r <= v[DW-1];
    x_r    <= x;
    en_r   <= en;
  end

  assign dx   = {1'b0, prod_r[PW-1:FRAC_BITS]};
  assign xs   = {{(SW-DW){x_r[DW-1]}}, x_r};
  assign sum  = vneg_r ? (xs - dx) : (xs + dx);
  assign fits = (&sum[SW-1:DW-1]) | ~(|sum[SW-1:DW-1]);

  always_comb begin
    x_nxt   = x_r;
    sat_nxt = 1'b0;
    if (en_r) begin
      if (fits) begin
        x_nxt = sum[DW-1:0];
      end else begin
        x_nxt   = sum[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        sat_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_new_r <= x_nxt;
    sat_r   <= sat_nxt;
  end

  assign x_new = x_new_r;
  assign sat   = sat_r;

endmodule

`default_nettype wire
